### design/pfjc_pkg.sv
package pfjc_pkg;

  // Build-time defaults
  localparam int NUM_JOINTS_DEF = 6;

  // Field widths
  localparam int JOINT_W   = 3;
  localparam int MASK_W    = 6;
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 24;
  localparam int TS_W      = 16;
  localparam int LIM_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;

  // Datapath widths
  localparam int MUL_A_W = DATA_W + 1;              // error difference needs 33 bits
  localparam int MUL_B_W = GAIN_W + 1;              // unsigned gain as signed operand
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int TERM_W  = PROD_W - FRAC_W;         // product after floor shift
  localparam int ISUM_W  = DATA_W + 2;              // history plus one increment
  localparam int ACC_W   = 45;                      // feed-forward plus three terms

  // Saturation bounds of a 32-bit signed word
  localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_INTEG_GAIN     = 3'd1,
    CFG_DERIV_GAIN     = 3'd2,
    CFG_TIME_STEP      = 3'd3,
    CFG_INTEGRAL_LIMIT = 3'd4,
    CFG_VELOCITY_LIMIT = 3'd5,
    CFG_ACTIVE_MASK    = 3'd6
  } cfg_reg_e;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 24'd655360;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST     = 24'd98304;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST     = 24'd655360;
  localparam logic [TS_W-1:0]   TIME_STEP_RST      = 16'd655;
  localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RST = 31'd163840;
  localparam logic [LIM_W-1:0]  VELOCITY_LIMIT_RST = 31'd49152;
  localparam logic [MASK_W-1:0] ACTIVE_MASK_RST    = 6'd0;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic signed [DATA_W-1:0] desired_position;
    logic signed [DATA_W-1:0] desired_velocity;
    logic signed [DATA_W-1:0] measured_position;
    logic                     clear_history;
  } in_item_t;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint_out;
    logic signed [DATA_W-1:0] command_velocity;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    value;
  } cfg_req_t;

  // Register file contents handed to the controller core
  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain_over_step;
    logic [TS_W-1:0]   time_step;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  velocity_limit;
    logic [MASK_W-1:0] active_mask;
  } settings_t;

endpackage

### design/pfjc_if.sv
// Joint tick request channel
interface pfjc_in_if;
  logic                valid;
  logic                ready;
  pfjc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Velocity command result channel
interface pfjc_out_if;
  logic                valid;
  logic                ready;
  pfjc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Register write channel
interface pfjc_cfg_if;
  logic                valid;
  logic                ready;
  pfjc_pkg::cfg_req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/pid_feedforward_joint_controller_top.sv
// PID velocity controller with feed-forward and anti-windup for up to
// NUM_JOINTS joints sharing one datapath.
//
// in_i carries one control tick per request: joint index, desired position,
// feed-forward velocity, measured position and a history clear flag. out_o
// returns one command per request, in order, with the joint index echoed
// and a flag when the velocity limit clipped the command. cfg_i writes the
// gains, time step, limits and active mask; it is always ready and must only
// be used while no request is in flight.
//
// An active joint runs through the error, product, accumulate and clamp
// steps before its result reaches the output register; the four products go
// through the single multiplier one after another (time step, P, I, D).
// Inactive or out-of-range joints go straight to the finish state from idle.
// in_i is ready only while the sequencer is idle, so a new request is taken
// only after the previous result has been handed to the output register.
//
// Reset restores the register defaults and clears every joint's history.
// A stalled out_o holds its result; the core finishes the next request and
// waits until the output register frees before committing it.
module pid_feedforward_joint_controller_top #(
  parameter int NUM_JOINTS = pfjc_pkg::NUM_JOINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfjc_in_if.sink     in_i,
  pfjc_out_if.source  out_o,
  pfjc_cfg_if.sink    cfg_i
);

  pfjc_pkg::settings_t settings_q;

  // Register file
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings_q.prop_gain            <= pfjc_pkg::PROP_GAIN_RST;
      settings_q.integ_gain           <= pfjc_pkg::INTEG_GAIN_RST;
      settings_q.deriv_gain_over_step <= pfjc_pkg::DERIV_GAIN_RST;
      settings_q.time_step            <= pfjc_pkg::TIME_STEP_RST;
      settings_q.integral_limit       <= pfjc_pkg::INTEGRAL_LIMIT_RST;
      settings_q.velocity_limit       <= pfjc_pkg::VELOCITY_LIMIT_RST;
      settings_q.active_mask          <= pfjc_pkg::ACTIVE_MASK_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (pfjc_pkg::cfg_reg_e'(cfg_i.data.index))
        pfjc_pkg::CFG_PROP_GAIN:
          settings_q.prop_gain <= cfg_i.data.value[pfjc_pkg::GAIN_W-1:0];
        pfjc_pkg::CFG_INTEG_GAIN:
          settings_q.integ_gain <= cfg_i.data.value[pfjc_pkg::GAIN_W-1:0];
        pfjc_pkg::CFG_DERIV_GAIN:
          settings_q.deriv_gain_over_step <= cfg_i.data.value[pfjc_pkg::GAIN_W-1:0];
        pfjc_pkg::CFG_TIME_STEP:
          settings_q.time_step <= cfg_i.data.value[pfjc_pkg::TS_W-1:0];
        pfjc_pkg::CFG_INTEGRAL_LIMIT:
          settings_q.integral_limit <= cfg_i.data.value[pfjc_pkg::LIM_W-1:0];
        pfjc_pkg::CFG_VELOCITY_LIMIT:
          settings_q.velocity_limit <= cfg_i.data.value[pfjc_pkg::LIM_W-1:0];
        pfjc_pkg::CFG_ACTIVE_MASK:
          settings_q.active_mask <= cfg_i.data.value[pfjc_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller core
  logic                res_valid;
  logic                res_ready;
  pfjc_pkg::out_item_t res_item;

  pfjc_core #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_i.data),
    .settings_i  (settings_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item)
  );

  // Output register
  logic                out_valid_q;
  pfjc_pkg::out_item_t out_item_q;

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_item_q <= res_item;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // Checks
  logic signed [pfjc_pkg::DATA_W-1:0] vlim_pos;
  logic signed [pfjc_pkg::DATA_W-1:0] vlim_neg;
  assign vlim_pos = {1'b0, settings_q.velocity_limit};
  assign vlim_neg = -vlim_pos;

  // The sequencer must go busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request channel still ready after a request was taken");

  // A clipped command sits exactly on the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.saturated) |->
      ((out_o.data.command_velocity == vlim_pos) ||
       (out_o.data.command_velocity == vlim_neg)))
    else $error("saturated command not at the velocity limit");

  // An unclipped command lies within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.saturated) |->
      ((out_o.data.command_velocity <= vlim_pos) &&
       (out_o.data.command_velocity >= vlim_neg)))
    else $error("command outside the velocity limit without saturation flag");

endmodule

### design/pfjc_mul.sv
// Shared signed multiplier with registered product
module pfjc_mul (
  input  logic                                 clk_i,
  input  logic signed [pfjc_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [pfjc_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [pfjc_pkg::PROD_W-1:0]   prod_o
);

  logic signed [pfjc_pkg::PROD_W-1:0] prod_q;
  logic signed [pfjc_pkg::PROD_W-1:0] prod_d;

  assign prod_d = pfjc_pkg::PROD_W'(a_i) * pfjc_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

### design/pfjc_core.sv
// Sequencer, per-joint history and accumulator around the shared multiplier
module pfjc_core #(
  parameter int NUM_JOINTS = pfjc_pkg::NUM_JOINTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pfjc_pkg::in_item_t    in_item_i,
  input  pfjc_pkg::settings_t   settings_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output pfjc_pkg::out_item_t   res_item_o
);

  localparam int IdxW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int DW   = pfjc_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_T,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC_D,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  pfjc_pkg::in_item_t            item_q;
  logic                          active_q;
  logic [IdxW-1:0]               idx_q;
  logic signed [DW-1:0]          e_q;
  logic signed [DW:0]            diff_q;
  logic signed [DW-1:0]          integ_q;
  logic signed [pfjc_pkg::ACC_W-1:0] acc_q;

  logic signed [DW-1:0] int_store_q  [NUM_JOINTS];
  logic signed [DW-1:0] perr_store_q [NUM_JOINTS];

  logic                 accept;
  logic                 joint_ok;
  logic                 joint_active;
  logic [IdxW-1:0]      in_idx;
  logic                 commit;

  // Handshake and joint decode
  assign in_ready_o   = (state_q == ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign joint_ok     = (32'(in_item_i.joint) < NUM_JOINTS) &&
                        (32'(in_item_i.joint) < pfjc_pkg::MASK_W);
  assign joint_active = joint_ok && settings_i.active_mask[in_item_i.joint];
  assign in_idx       = IdxW'(in_item_i.joint);
  assign commit       = (state_q == ST_FINISH) && res_ready_i;

  // History of the joint in flight
  logic signed [DW-1:0] int_hist;
  logic signed [DW-1:0] perr_hist;
  assign int_hist  = int_store_q[idx_q];
  assign perr_hist = perr_store_q[idx_q];

  // Saturated position error
  logic signed [DW:0]   pos_diff;
  logic signed [DW-1:0] e_sat;
  assign pos_diff = (DW+1)'(item_q.desired_position) - (DW+1)'(item_q.measured_position);
  always_comb begin
    if (pos_diff[DW] != pos_diff[DW-1]) begin
      e_sat = pos_diff[DW] ? pfjc_pkg::INT_MIN : pfjc_pkg::INT_MAX;
    end else begin
      e_sat = pos_diff[DW-1:0];
    end
  end

  // Multiplier operand selection
  logic signed [pfjc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pfjc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pfjc_pkg::PROD_W-1:0]  prod;
  logic signed [pfjc_pkg::TERM_W-1:0]  term;

  always_comb begin
    case (state_q)
      ST_MUL_P: begin
        mul_a = pfjc_pkg::MUL_A_W'(e_q);
        mul_b = {1'b0, settings_i.prop_gain};
      end
      ST_MUL_I: begin
        mul_a = pfjc_pkg::MUL_A_W'(integ_q);
        mul_b = {1'b0, settings_i.integ_gain};
      end
      ST_MUL_D: begin
        mul_a = diff_q;
        mul_b = {1'b0, settings_i.deriv_gain_over_step};
      end
      default: begin
        mul_a = pfjc_pkg::MUL_A_W'(e_q);
        mul_b = {{(pfjc_pkg::MUL_B_W - pfjc_pkg::TS_W){1'b0}}, settings_i.time_step};
      end
    endcase
  end

  pfjc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Floor division by 2^16 is the upper slice of the product
  assign term = prod[pfjc_pkg::PROD_W-1:pfjc_pkg::FRAC_W];

  // Integral update with anti-windup clamp
  logic signed [pfjc_pkg::ISUM_W-1:0] isum;
  logic signed [pfjc_pkg::ISUM_W-1:0] ilim;
  logic signed [pfjc_pkg::ISUM_W-1:0] ilim_neg;
  logic signed [DW-1:0]               integ_clamped;
  assign isum     = pfjc_pkg::ISUM_W'(int_hist) + pfjc_pkg::ISUM_W'(term);
  assign ilim     = {{(pfjc_pkg::ISUM_W - pfjc_pkg::LIM_W){1'b0}}, settings_i.integral_limit};
  assign ilim_neg = -ilim;
  always_comb begin
    if (isum > ilim) begin
      integ_clamped = ilim[DW-1:0];
    end else if (isum < ilim_neg) begin
      integ_clamped = ilim_neg[DW-1:0];
    end else begin
      integ_clamped = isum[DW-1:0];
    end
  end

  // Output clamp
  logic signed [pfjc_pkg::ACC_W-1:0] vlim;
  logic signed [pfjc_pkg::ACC_W-1:0] vlim_neg;
  logic signed [DW-1:0]              cmd;
  logic                              sat;
  assign vlim     = {{(pfjc_pkg::ACC_W - pfjc_pkg::LIM_W){1'b0}}, settings_i.velocity_limit};
  assign vlim_neg = -vlim;
  always_comb begin
    if (!active_q) begin
      cmd = '0;
      sat = 1'b0;
    end else if (acc_q > vlim) begin
      cmd = vlim[DW-1:0];
      sat = 1'b1;
    end else if (acc_q < vlim_neg) begin
      cmd = vlim_neg[DW-1:0];
      sat = 1'b1;
    end else begin
      cmd = acc_q[DW-1:0];
      sat = 1'b0;
    end
  end

  assign res_valid_o                 = (state_q == ST_FINISH);
  assign res_item_o.joint_out        = item_q.joint;
  assign res_item_o.command_velocity = cmd;
  assign res_item_o.saturated        = sat;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = joint_active ? ST_ERR : ST_FINISH;
      ST_ERR:    state_d = ST_MUL_T;
      ST_MUL_T:  state_d = ST_MUL_P;
      ST_MUL_P:  state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_MUL_D;
      ST_MUL_D:  state_d = ST_ACC_D;
      ST_ACC_D:  state_d = ST_FINISH;
      ST_FINISH: if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) active_q <= joint_active;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      idx_q  <= in_idx;
    end
    case (state_q) inside
      ST_ERR: begin
        e_q   <= e_sat;
        acc_q <= pfjc_pkg::ACC_W'(item_q.desired_velocity);
      end
      ST_MUL_T: diff_q  <= (DW+1)'(e_q) - (DW+1)'(perr_hist);
      ST_MUL_P: integ_q <= integ_clamped;
      ST_MUL_I, ST_MUL_D, ST_ACC_D: acc_q <= acc_q + pfjc_pkg::ACC_W'(term);
      default: ;
    endcase
  end

  // Per-joint integral and previous error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_JOINTS; k++) begin
        int_store_q[k]  <= '0;
        perr_store_q[k] <= '0;
      end
    end else if (accept && joint_ok && in_item_i.clear_history) begin
      int_store_q[in_idx]  <= '0;
      perr_store_q[in_idx] <= '0;
    end else if (commit && active_q) begin
      int_store_q[idx_q]  <= integ_q;
      perr_store_q[idx_q] <= e_q;
    end
  end

endmodule
